### rtl/bbal_pkg.sv
// ----------------------------------------------------------------------------
// bbal_pkg
// Shared constants, types and helpers of the bitmap buddy allocator.
// ----------------------------------------------------------------------------
package bbal_pkg;

  localparam int unsigned ENTRIES_PER_PAGE = 512;
  localparam int unsigned MAX_PAGES        = 8;
  localparam int unsigned NUM_LEVELS       = 13;

  localparam int unsigned MAX_ENTRIES = MAX_PAGES * ENTRIES_PER_PAGE;
  localparam int unsigned ENT_W       = $clog2(MAX_ENTRIES) + 1;
  localparam int unsigned BLK_W       = ENT_W - 1;
  localparam int unsigned LVL_W       = 4;
  localparam int unsigned WORD_W      = $clog2(MAX_ENTRIES / 32);
  localparam int unsigned ADDR_W      = LVL_W + WORD_W;
  localparam int unsigned RAM_DEPTH   = 2 ** ADDR_W;
  localparam int unsigned PAGES_W     = 4;

  localparam logic [31:0] TOP_BIT = 32'h8000_0000;

  localparam logic REG_TABLE_PAGES = 1'b0;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_NOFREE = 3'd1,
    ST_ORDER  = 3'd2,
    ST_ALIGN  = 3'd3,
    ST_RANGE  = 3'd4
  } status_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } op_e;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [31:0]       wdata;
    logic [ADDR_W-1:0] raddr;
  } ram_req_t;

  function automatic logic [LVL_W-1:0] top_of(input logic [ENT_W-1:0] entries);
    logic [LVL_W-1:0] t;
    t = '0;
    for (int l = 0; l < NUM_LEVELS; l++) begin
      if ((entries >> l) != '0) t = LVL_W'(l);
    end
    return t;
  endfunction

  function automatic logic [4:0] lead_one(input logic [31:0] w);
    logic [4:0] idx;
    idx = '0;
    for (int i = 0; i < 32; i++) begin
      if (w[i]) idx = 5'(31 - i);
    end
    return idx;
  endfunction

endpackage

### rtl/multilevel_bitmap_buddy_allocator.sv
// ----------------------------------------------------------------------------
// multilevel_bitmap_buddy_allocator
// Buddy allocator with one free bitmap per power-of-two level in one RAM.
// ----------------------------------------------------------------------------
//  channel   ports                                   handshake
//  request   op_i, order_i, entry_i                  start & !busy
//  result    status_o, entry_out_o                   done_o, one cycle
//  config    psel penable pwrite paddr pwdata prdata APB write, pready high
//
// Each bitmap word is read from RAM, then evaluated and written back.
// Allocate scans up to 128 words per level; each split or merge step reads
// and rewrites one word. Order, alignment and range errors answer in the cycle
// after start. A reset or a table_pages write rebuilds all 13 level maps.
// busy is high while a request or the rebuild runs; results cannot be stalled.
// ----------------------------------------------------------------------------
module multilevel_bitmap_buddy_allocator (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic        op_i,
  input  logic [3:0]  order_i,
  input  logic [11:0] entry_i,
  output logic        done_o,
  output logic [2:0]  status_o,
  output logic [11:0] entry_out_o
);
  import bbal_pkg::*;

  logic [PAGES_W-1:0] pages_q;
  logic               cfg_wr;
  ram_req_t           ram_req;
  logic [31:0]        ram_rdata;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready && (paddr[2] == REG_TABLE_PAGES);
  assign prdata = (paddr[2] == REG_TABLE_PAGES) ? {28'b0, pages_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pages_q <= PAGES_W'(MAX_PAGES);
    end else if (cfg_wr) begin
      pages_q <= pwdata[PAGES_W-1:0];
    end
  end

  bbal_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_wr_i    (cfg_wr),
    .pages_i     (pages_q),
    .start       (start),
    .busy        (busy),
    .op_i        (op_i),
    .order_i     (order_i),
    .entry_i     (entry_i),
    .done_o      (done_o),
    .status_o    (status_o),
    .entry_out_o (entry_out_o),
    .ram_req_o   (ram_req),
    .ram_rdata_i (ram_rdata)
  );

  bbal_ram #(
    .WIDTH (32),
    .DEPTH (RAM_DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_req.we),
    .waddr_i (ram_req.waddr),
    .wdata_i (ram_req.wdata),
    .raddr_i (ram_req.raddr),
    .rdata_o (ram_rdata)
  );

`ifndef SYNTHESIS
  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> (status_o <= 3'd4))
    else $error("status code out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o != ST_OK) |-> (entry_out_o == '0))
    else $error("nonzero entry on error result");

  a_cfg_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> busy)
    else $error("map rebuild did not start after config write");

  a_cfg_rd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_wr |=> (pages_q == $past(pwdata[3:0])))
    else $error("table_pages not written");
`endif

endmodule

### rtl/bbal_ram.sv
// ----------------------------------------------------------------------------
// bbal_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module bbal_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 2048
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

### rtl/bbal_core.sv
// ----------------------------------------------------------------------------
// bbal_core
// Sequencer: map init sweep, word scan and split for allocate, bit set and buddy merge.
// ----------------------------------------------------------------------------
module bbal_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      cfg_wr_i,
  input  logic [bbal_pkg::PAGES_W-1:0] pages_i,
  input  logic                      start,
  output logic                      busy,
  input  logic                      op_i,
  input  logic [3:0]                order_i,
  input  logic [11:0]               entry_i,
  output logic                      done_o,
  output logic [2:0]                status_o,
  output logic [11:0]               entry_out_o,
  output bbal_pkg::ram_req_t        ram_req_o,
  input  logic [31:0]               ram_rdata_i
);
  import bbal_pkg::*;

  typedef enum logic [5:0] {
    S_INIT = 6'b000001,
    S_IDLE = 6'b000010,
    S_SRD  = 6'b000100,
    S_SEV  = 6'b001000,
    S_FRD  = 6'b010000,
    S_FEV  = 6'b100000
  } state_e;

  state_e              state_q, state_d;
  op_e                 op_q, op_d;
  logic [LVL_W-1:0]    ord_q, ord_d, lvl_q, lvl_d, desc_q, desc_d;
  logic [WORD_W-1:0]   word_q, word_d;
  logic [BLK_W-1:0]    blk_q, blk_d, ent_q, ent_d;
  logic                done_q, done_d;
  status_e             status_q, status_d;
  logic [11:0]         eout_q, eout_d;

  logic [PAGES_W-1:0]  pages_eff;
  logic [ENT_W-1:0]    entries, n_cur, n_ord;
  logic [LVL_W-1:0]    top;
  logic [WORD_W:0]     words_cur;
  logic [BLK_W-1:0]    blk_in, ent_found;
  logic [4:0]          lead;
  logic [31:0]         bit_self, pair, w_set;
  logic                merge_ok, merge;

  function automatic logic [31:0] init_word(input logic [ENT_W-1:0] n,
                                            input logic is_top,
                                            input logic [WORD_W-1:0] w);
    logic [ENT_W-1:0] base, rem, last;
    logic [31:0]      r;
    base = {1'b0, w, 5'b0};
    rem  = n - base;
    last = n - ENT_W'(1);
    r    = '0;
    if (is_top && n > base) begin
      r = (rem >= ENT_W'(32)) ? 32'hffff_ffff : ~(32'hffff_ffff >> rem[4:0]);
    end
    if (n[0] && last[ENT_W-2:5] == w) begin
      r = r | (TOP_BIT >> last[4:0]);
    end
    return r;
  endfunction

  assign pages_eff = (pages_i == '0) ? PAGES_W'(1) :
                     (pages_i > PAGES_W'(MAX_PAGES)) ? PAGES_W'(MAX_PAGES) : pages_i;
  assign entries   = ENT_W'(pages_eff) * ENT_W'(ENTRIES_PER_PAGE);
  assign top       = top_of(entries);
  assign n_cur     = entries >> lvl_q;
  assign n_ord     = entries >> order_i;
  assign words_cur = (WORD_W+1)'((n_cur + ENT_W'(31)) >> 5);
  assign blk_in    = entry_i >> order_i;
  assign lead      = lead_one(ram_rdata_i);
  assign ent_found = BLK_W'({word_q, lead}) << lvl_q;

  assign bit_self = TOP_BIT >> blk_q[4:0];
  assign pair     = (TOP_BIT >> {blk_q[4:1], 1'b0}) | (TOP_BIT >> {blk_q[4:1], 1'b1});
  assign w_set    = ram_rdata_i | bit_self;
  assign merge_ok = (lvl_q < top) &&
                    (!n_cur[0] || {1'b0, blk_q} < n_cur - ENT_W'(1)) &&
                    ({1'b0, blk_q} > (n_cur >> 2));
  assign merge    = merge_ok && ((w_set & pair) == pair);

  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    ord_d     = ord_q;
    lvl_d     = lvl_q;
    desc_d    = desc_q;
    word_d    = word_q;
    blk_d     = blk_q;
    ent_d     = ent_q;
    done_d    = 1'b0;
    status_d  = status_q;
    eout_d    = eout_q;
    ram_req_o = '0;

    unique case (state_q)
      S_INIT: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = {lvl_q, word_q};
        ram_req_o.wdata = init_word(n_cur, lvl_q == top, word_q);
        word_d = word_q + WORD_W'(1);
        if (word_q == '1) begin
          if (lvl_q == LVL_W'(NUM_LEVELS - 1)) begin
            state_d = S_IDLE;
            lvl_d   = '0;
          end else begin
            lvl_d = lvl_q + LVL_W'(1);
          end
        end
      end
      S_IDLE: begin
        if (start) begin
          op_d  = op_e'(op_i);
          ord_d = order_i;
          lvl_d = order_i;
          if (order_i > top) begin
            done_d   = 1'b1;
            status_d = ST_ORDER;
            eout_d   = '0;
          end else if (op_e'(op_i) == OP_ALLOC) begin
            word_d  = '0;
            state_d = S_SRD;
          end else if ((entry_i & ~(12'hfff << order_i)) != '0) begin
            done_d   = 1'b1;
            status_d = ST_ALIGN;
            eout_d   = '0;
          end else if ({1'b0, blk_in} >= n_ord) begin
            done_d   = 1'b1;
            status_d = ST_RANGE;
            eout_d   = '0;
          end else begin
            blk_d   = blk_in;
            state_d = S_FRD;
          end
        end
      end
      S_SRD: begin
        ram_req_o.raddr = {lvl_q, word_q};
        state_d = S_SEV;
      end
      S_SEV: begin
        if (ram_rdata_i != '0) begin
          ram_req_o.we    = 1'b1;
          ram_req_o.waddr = {lvl_q, word_q};
          ram_req_o.wdata = ram_rdata_i ^ (TOP_BIT >> lead);
          ent_d = ent_found;
          if (lvl_q == ord_q) begin
            done_d   = 1'b1;
            status_d = ST_OK;
            eout_d   = ent_found;
            state_d  = S_IDLE;
          end else begin
            desc_d  = lvl_q - LVL_W'(1);
            lvl_d   = lvl_q - LVL_W'(1);
            blk_d   = (ent_found >> (lvl_q - LVL_W'(1))) | BLK_W'(1);
            state_d = S_FRD;
          end
        end else if (({1'b0, word_q} + (WORD_W+1)'(1)) < words_cur) begin
          word_d  = word_q + WORD_W'(1);
          state_d = S_SRD;
        end else if (lvl_q < top) begin
          lvl_d   = lvl_q + LVL_W'(1);
          word_d  = '0;
          state_d = S_SRD;
        end else begin
          done_d   = 1'b1;
          status_d = ST_NOFREE;
          eout_d   = '0;
          state_d  = S_IDLE;
        end
      end
      S_FRD: begin
        ram_req_o.raddr = {lvl_q, blk_q[BLK_W-1:5]};
        state_d = S_FEV;
      end
      S_FEV: begin
        ram_req_o.we    = 1'b1;
        ram_req_o.waddr = {lvl_q, blk_q[BLK_W-1:5]};
        ram_req_o.wdata = merge ? (w_set & ~pair) : w_set;
        if (merge) begin
          lvl_d   = lvl_q + LVL_W'(1);
          blk_d   = {1'b0, blk_q[BLK_W-1:1]};
          state_d = S_FRD;
        end else if (op_q == OP_FREE) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          eout_d   = '0;
          state_d  = S_IDLE;
        end else if (desc_q == ord_q) begin
          done_d   = 1'b1;
          status_d = ST_OK;
          eout_d   = ent_q;
          state_d  = S_IDLE;
        end else begin
          desc_d  = desc_q - LVL_W'(1);
          lvl_d   = desc_q - LVL_W'(1);
          blk_d   = (ent_q >> (desc_q - LVL_W'(1))) | BLK_W'(1);
          state_d = S_FRD;
        end
      end
      default: state_d = S_IDLE;
    endcase

    if (cfg_wr_i) begin
      state_d = S_INIT;
      lvl_d   = '0;
      word_d  = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_INIT;
      lvl_q    <= '0;
      word_q   <= '0;
      done_q   <= 1'b0;
      status_q <= ST_OK;
      eout_q   <= '0;
    end else begin
      state_q  <= state_d;
      lvl_q    <= lvl_d;
      word_q   <= word_d;
      done_q   <= done_d;
      status_q <= status_d;
      eout_q   <= eout_d;
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    ord_q  <= ord_d;
    desc_q <= desc_d;
    blk_q  <= blk_d;
    ent_q  <= ent_d;
  end

  assign busy        = (state_q != S_IDLE);
  assign done_o      = done_q;
  assign status_o    = status_q;
  assign entry_out_o = eout_q;

endmodule
